// ===== hdl/rsmix_pkg.sv =====
// Shared types and constants for the two-source resampling mixer.
package rsmix_pkg;

   // Source encodings held in the format registers
   localparam logic [2:0] FMT_NONE    = 3'd0;
   localparam logic [2:0] FMT_PCM8    = 3'd1;
   localparam logic [2:0] FMT_PCM16   = 3'd2;
   localparam logic [2:0] FMT_PCM24   = 3'd3;
   localparam logic [2:0] FMT_PCM32   = 3'd4;
   localparam logic [2:0] FMT_FLOAT32 = 3'd5;

   // Configuration register indexes
   localparam logic CSR_FORMAT_A = 1'b0;
   localparam logic CSR_FORMAT_B = 1'b1;

   // Output scaling and limit
   localparam logic signed [15:0] OUT_SCALE = 16'sd32767;
   localparam logic signed [19:0] OUT_MAX   = 20'sd32767;

   // Decoded sample width: signed, full scale is 2^31
   localparam int SAMPLE_W = 33;

   // Load enables for the three interpolation stages
   typedef struct packed {
      logic dec_load;
      logic mul_load;
      logic add_load;
   } stage_adv_type;

endpackage

// ===== hdl/rsmix_req_if.sv =====
// Channel interfaces for input items and mixed results.
interface rsmix_req_if;
   logic        valid;
   logic        ready;
   logic        a_active;
   logic [31:0] a_word_now;
   logic [31:0] a_word_next;
   logic [15:0] a_fraction;
   logic        b_active;
   logic [31:0] b_word_now;
   logic [31:0] b_word_next;
   logic [15:0] b_fraction;

   modport source (output valid, a_active, a_word_now, a_word_next, a_fraction,
                   b_active, b_word_now, b_word_next, b_fraction, input ready);
   modport sink (input valid, a_active, a_word_now, a_word_next, a_fraction,
                 b_active, b_word_now, b_word_next, b_fraction, output ready);
endinterface

interface rsmix_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] mixed_sample;
   logic [1:0]         active_count;

   modport source (output valid, mixed_sample, active_count, input ready);
   modport sink (input valid, mixed_sample, active_count, output ready);
endinterface

// ===== hdl/rsmix_lerp.sv =====
// Decode and linear interpolation of one source over three register stages.
module rsmix_lerp (
   input  logic                                   clock,
   input  rsmix_pkg::stage_adv_type               adv,
   input  logic [2:0]                             format,
   input  logic [31:0]                            word_now,
   input  logic [31:0]                            word_next,
   input  logic [15:0]                            fraction,
   output logic signed [rsmix_pkg::SAMPLE_W-1:0]  interp
);

   localparam int SW = rsmix_pkg::SAMPLE_W;

   // Turn a float32 word into signed Q1.31, clamped and truncated
   function automatic logic signed [SW-1:0] decode_float(input logic [31:0] w);
      logic [7:0]  expo;
      logic [22:0] mant;
      logic [31:0] m24;
      logic [31:0] mag;
      logic [7:0]  rsh;
      logic [2:0]  lsh;
      expo = w[30:23];
      mant = w[22:0];
      m24  = {9'd0, mant} | 32'h0080_0000;
      rsh  = 8'd119 - expo;
      lsh  = 3'(expo - 8'd119);
      if (expo == 8'd255 && mant != 23'd0) begin
         mag = 32'd0;
      end else if (expo >= 8'd127) begin
         mag = 32'h8000_0000;
      end else if (expo == 8'd0) begin
         mag = 32'd0;
      end else if (expo >= 8'd119) begin
         mag = m24 << lsh;
      end else begin
         mag = m24 >> rsh;
      end
      if (w[31]) begin
         decode_float = -$signed({1'b0, mag});
      end else begin
         decode_float = $signed({1'b0, mag});
      end
   endfunction

   // Decode one raw word according to the source format
   function automatic logic signed [SW-1:0] decode_word(input logic [2:0]  fmt,
                                                         input logic [31:0] w);
      logic signed [SW-1:0] res;
      case (fmt)
         rsmix_pkg::FMT_PCM8: begin
            res = $signed({~w[7], {25{~w[7]}}, w[6:0]}) <<< 24;
         end
         rsmix_pkg::FMT_PCM16: begin
            res = $signed({w[15], w[15:0], 16'd0});
         end
         rsmix_pkg::FMT_PCM24: begin
            res = $signed({{2{w[23]}}, w[22:0], 8'd0});
         end
         rsmix_pkg::FMT_PCM32: begin
            res = $signed({w[31], w});
         end
         rsmix_pkg::FMT_FLOAT32: begin
            res = decode_float(w);
         end
         default: begin
            res = '0;
         end
      endcase
      decode_word = res;
   endfunction

   logic signed [SW-1:0] s0_ff, s0_in, s1_ff, s1_in;
   logic [15:0]          frac_ff;
   logic signed [SW-1:0] base_ff;
   logic signed [SW:0]   diff;
   logic signed [SW+17:0] prod_ff, prod_in;
   logic signed [SW+1:0] prod_sh;
   logic signed [SW+1:0] sum_full;
   logic signed [SW-1:0] interp_ff, interp_in;

   // Stage 1: decode both frames
   always_comb begin
      s0_in = decode_word(format, word_now);
      s1_in = decode_word(format, word_next);
   end

   always_ff @(posedge clock) begin
      if (adv.dec_load) begin
         s0_ff   <= s0_in;
         s1_ff   <= s1_in;
         frac_ff <= fraction;
      end
   end

   // Stage 2: scale the frame difference by the fraction
   always_comb begin
      diff    = {s1_ff[SW-1], s1_ff} - {s0_ff[SW-1], s0_ff};
      prod_in = diff * $signed({1'b0, frac_ff});
   end

   always_ff @(posedge clock) begin
      if (adv.mul_load) begin
         prod_ff <= prod_in;
         base_ff <= s0_ff;
      end
   end

   // Stage 3: floor shift and add to the base frame
   always_comb begin
      prod_sh   = prod_ff[SW+17:16];
      sum_full  = {{2{base_ff[SW-1]}}, base_ff} + prod_sh;
      interp_in = sum_full[SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv.add_load) begin
         interp_ff <= interp_in;
      end
   end

   assign interp = interp_ff;

endmodule

// ===== hdl/resample_mix_two_sources.sv =====
// Top level of the two-source linear interpolation mixer.
//
// Channel  Dir  Payload                                         Handshake
// req_if   in   a/b active, word_now, word_next, fraction       valid/ready
// rsp_if   out  mixed_sample, active_count                      valid/ready
// csr_*    in   format_a (index 0), format_b (index 1), 3 bits  write enable
//
// One item enters per cycle while no stall reaches back to the input; each result
// passes through the six register stages (decode, fraction product, interpolate,
// sum and clamp, output scale product, rounding).
// Each stage holds while the stage after it is full and stalled, so a stall
// loses and repeats nothing; an empty stage loads even during a stall.
// Synchronous reset clears the valid bits and sets both formats to pcm16.
module resample_mix_two_sources (
   input  logic               clock,
   input  logic               reset,
   rsmix_req_if.sink          req_if,
   rsmix_rsp_if.source        rsp_if,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [2:0]         csr_wdata
);

   localparam int SW = rsmix_pkg::SAMPLE_W;
   localparam int NS = 6;

   logic [2:0] format_a_ff, format_b_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         format_a_ff <= rsmix_pkg::FMT_PCM16;
         format_b_ff <= rsmix_pkg::FMT_PCM16;
      end else if (csr_write) begin
         if (csr_index == rsmix_pkg::CSR_FORMAT_A) begin
            format_a_ff <= csr_wdata;
         end
         if (csr_index == rsmix_pkg::CSR_FORMAT_B) begin
            format_b_ff <= csr_wdata;
         end
      end
   end

   // Stage valid bits and the backward ready chain
   logic [NS-1:0] valid_ff, valid_in;
   logic [NS-1:0] load;
   logic [NS-1:0] upstream;

   always_comb begin
      load[NS-1] = !valid_ff[NS-1] || rsp_if.ready;
      for (int k = NS - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      upstream = {valid_ff[NS-2:0], req_if.valid};
      for (int k = 0; k < NS; k++) begin
         valid_in[k] = load[k] ? upstream[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_if.ready = load[0];

   rsmix_pkg::stage_adv_type adv;
   assign adv.dec_load = load[0];
   assign adv.mul_load = load[1];
   assign adv.add_load = load[2];

   // Per-source interpolation, stages 1 to 3
   logic signed [SW-1:0] interp_a, interp_b;

   rsmix_lerp u_lerp_a (
      .clock     (clock),
      .adv       (adv),
      .format    (format_a_ff),
      .word_now  (req_if.a_word_now),
      .word_next (req_if.a_word_next),
      .fraction  (req_if.a_fraction),
      .interp    (interp_a)
   );

   rsmix_lerp u_lerp_b (
      .clock     (clock),
      .adv       (adv),
      .format    (format_b_ff),
      .word_now  (req_if.b_word_now),
      .word_next (req_if.b_word_next),
      .fraction  (req_if.b_fraction),
      .interp    (interp_b)
   );

   // Carry the active flags alongside the interpolation stages
   logic [2:0] act_a_ff, act_b_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (load[k]) begin
            act_a_ff[k] <= (k == 0) ? req_if.a_active : act_a_ff[(k == 0) ? 0 : k - 1];
            act_b_ff[k] <= (k == 0) ? req_if.b_active : act_b_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   // Stage 4: sum active sources and clamp to full scale, doubled when both are active
   logic signed [SW:0] sum_ff, sum_in, sum_raw, limit;
   logic [1:0]         count4_ff, count4_in;

   always_comb begin
      sum_raw = '0;
      if (act_a_ff[2]) begin
         sum_raw = sum_raw + {interp_a[SW-1], interp_a};
      end
      if (act_b_ff[2]) begin
         sum_raw = sum_raw + {interp_b[SW-1], interp_b};
      end
      count4_in = {1'b0, act_a_ff[2]} + {1'b0, act_b_ff[2]};
      limit = (count4_in == 2'd2) ? $signed((SW+1)'(1) <<< 32)
                                  : $signed((SW+1)'(1) <<< 31);
      if (sum_raw > limit) begin
         sum_in = limit;
      end else if (sum_raw < -limit) begin
         sum_in = -limit;
      end else begin
         sum_in = sum_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         sum_ff    <= sum_in;
         count4_ff <= count4_in;
      end
   end

   // Stage 5: scale to the 16-bit output range
   logic signed [SW+16:0] scaled_ff, scaled_in;
   logic [1:0]            count5_ff;

   assign scaled_in = sum_ff * rsmix_pkg::OUT_SCALE;

   always_ff @(posedge clock) begin
      if (load[4]) begin
         scaled_ff <= scaled_in;
         count5_ff <= count4_ff;
      end
   end

   // Stage 6: round half to even and clamp
   logic signed [18:0] q;
   logic               half_bit, rest_nz, round_up;
   logic signed [19:0] q_rnd, q_clamp;
   logic signed [15:0] mixed_ff, mixed_in;
   logic [1:0]         count6_ff;

   always_comb begin
      if (count5_ff == 2'd2) begin
         q        = 19'(scaled_ff >>> 32);
         half_bit = scaled_ff[31];
         rest_nz  = |scaled_ff[30:0];
      end else begin
         q        = 19'(scaled_ff >>> 31);
         half_bit = scaled_ff[30];
         rest_nz  = |scaled_ff[29:0];
      end
      round_up = half_bit && (rest_nz || q[0]);
      q_rnd    = {q[18], q} + {19'd0, round_up};
      if (q_rnd > rsmix_pkg::OUT_MAX) begin
         q_clamp = rsmix_pkg::OUT_MAX;
      end else if (q_rnd < -rsmix_pkg::OUT_MAX) begin
         q_clamp = -rsmix_pkg::OUT_MAX;
      end else begin
         q_clamp = q_rnd;
      end
      mixed_in = q_clamp[15:0];
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         mixed_ff  <= mixed_in;
         count6_ff <= count5_ff;
      end
   end

   assign rsp_if.valid        = valid_ff[NS-1];
   assign rsp_if.mixed_sample = mixed_ff;
   assign rsp_if.active_count = count6_ff;

   // Pipeline occupancy follows input and output transfers
   property p_occupancy;
      @(posedge clock) disable iff (reset)
         ##1 $countones(valid_ff) == $countones($past(valid_ff))
             + ($past(req_if.valid && req_if.ready) ? 1 : 0)
             - ($past(rsp_if.valid && rsp_if.ready) ? 1 : 0);
   endproperty
   a_occupancy: assert property (p_occupancy)
      else $error("pipeline occupancy out of step with transfers");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.active_count != 2'd3)
      else $error("active count above two");

   a_silent_mix: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.active_count == 2'd0 |-> rsp_if.mixed_sample == 16'sd0)
      else $error("nonzero sample with no active source");

   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.mixed_sample >= -16'sd32767)
      else $error("mixed sample below clamp");

endmodule
